// ===== design/lcs_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// LCS package
// Shared constants, operation codes and types of the longest common
// subsequence core.
// ----------------------------------------------------------------------------
package lcs_pkg;

    localparam int FIRST_MAX_DEF  = 64;
    localparam int SECOND_MAX_DEF = 64;
    localparam int RESULT_CAP     = 64;

    localparam int OP_W     = 2;
    localparam int SYM_W    = 8;
    localparam int LENOUT_W = 7;

    localparam logic [OP_W-1:0] OP_FIRST   = 2'd0;
    localparam logic [OP_W-1:0] OP_SECOND  = 2'd1;
    localparam logic [OP_W-1:0] OP_COMPUTE = 2'd2;

    // Flags from the shared compare unit.
    typedef struct packed {
        logic match;
        logic up_eq;
    } lcs_flags_t;

    // One result as it leaves the engine.
    typedef struct packed {
        logic [LENOUT_W-1:0] lcs_length;
        logic [SYM_W-1:0]    out_symbol;
        logic                symbol_valid;
        logic                last;
    } lcs_res_t;

endpackage
`default_nettype wire

// ===== design/lcs_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// LCS compare unit
// Shared symbol compare, score compare and max/increment logic used by both
// the table fill and the traceback.
// ----------------------------------------------------------------------------
module lcs_unit #(
    parameter int SW = 7
) (
    input  wire logic [lcs_pkg::SYM_W-1:0] sym_a,
    input  wire logic [lcs_pkg::SYM_W-1:0] sym_b,
    input  wire logic [SW-1:0]             diag,
    input  wire logic [SW-1:0]             up,
    input  wire logic [SW-1:0]             left,
    input  wire logic [SW-1:0]             cur,
    output lcs_pkg::lcs_flags_t            flags,
    output logic      [SW-1:0]             value
);

    always_comb begin
        flags.match = (sym_a == sym_b);
        flags.up_eq = (cur == up);
        if (flags.match) begin
            value = diag + SW'(1);
        end else if (up > left) begin
            value = up;
        end else begin
            value = left;
        end
    end

endmodule
`default_nettype wire

// ===== design/lcs_engine.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// LCS engine
// String stores, score table, sequencer for table fill, traceback and
// result emission.
// ----------------------------------------------------------------------------
module lcs_engine #(
    parameter int FIRST_MAX  = lcs_pkg::FIRST_MAX_DEF,
    parameter int SECOND_MAX = lcs_pkg::SECOND_MAX_DEF
) (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       in_valid,
    output logic                            in_ready,
    input  wire logic [lcs_pkg::OP_W-1:0]   in_operation,
    input  wire logic [lcs_pkg::SYM_W-1:0]  in_symbol,
    output logic                            res_valid,
    input  wire logic                       res_ready,
    output lcs_pkg::lcs_res_t               res
);

    localparam int LW        = $clog2(FIRST_MAX + 1);
    localparam int SLW       = $clog2(SECOND_MAX + 1);
    localparam int SW        = LW;
    localparam int FAW       = (FIRST_MAX > 1) ? $clog2(FIRST_MAX) : 1;
    localparam int SAW       = (SECOND_MAX > 1) ? $clog2(SECOND_MAX) : 1;
    localparam int TBL_DEPTH = (FIRST_MAX + 1) * (SECOND_MAX + 1);
    localparam int AW        = $clog2(TBL_DEPTH);
    localparam int W2        = SW + lcs_pkg::LENOUT_W;
    localparam logic [AW-1:0] ROW_W = AW'(SECOND_MAX + 1);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_FCELL = 3'd1;
    localparam logic [2:0] ST_FWR   = 3'd2;
    localparam logic [2:0] ST_TCHK  = 3'd3;
    localparam logic [2:0] ST_TCUR  = 3'd4;
    localparam logic [2:0] ST_TDEC  = 3'd5;
    localparam logic [2:0] ST_ERD   = 3'd6;
    localparam logic [2:0] ST_EOUT  = 3'd7;

    logic [2:0]     state_reg, state_next;
    logic [LW-1:0]  fl_reg, fl_next;
    logic [SLW-1:0] sl_reg, sl_next;
    logic [LW-1:0]  i_reg, i_next;
    logic [SLW-1:0] j_reg, j_next;
    logic [AW-1:0]  addr_reg, addr_next;
    logic [SW-1:0]  diag_reg, diag_next;
    logic [SW-1:0]  left_reg, left_next;
    logic [SW-1:0]  cur_reg, cur_next;
    logic [SW-1:0]  len_reg, len_next;
    logic [SW-1:0]  k_reg, k_next;
    logic [SW-1:0]  lastk_reg, lastk_next;
    logic [FAW-1:0] ek_reg, ek_next;
    logic           empty_reg, empty_next;

    // Memories and their read data registers.
    logic [lcs_pkg::SYM_W-1:0] a_mem [FIRST_MAX];
    logic [lcs_pkg::SYM_W-1:0] b_mem [SECOND_MAX];
    logic [SW-1:0]             t_mem [TBL_DEPTH];
    logic [lcs_pkg::SYM_W-1:0] q_mem [FIRST_MAX];
    logic [lcs_pkg::SYM_W-1:0] a_rdata_reg, b_rdata_reg, q_rdata_reg;
    logic [SW-1:0]             t_rdata_reg;

    logic           a_we, a_re, b_we, b_re, t_we, t_re, q_we, q_re;
    logic [FAW-1:0] a_waddr, a_raddr, q_waddr, q_raddr;
    logic [SAW-1:0] b_waddr, b_raddr;
    logic [AW-1:0]  t_waddr, t_raddr;
    logic [SW-1:0]  t_wdata;

    logic                accept;
    logic                go_emit;
    logic                border;
    logic [SW-1:0]       wval;
    logic [LW-1:0]       i_dec;
    logic [SLW-1:0]      j_dec;
    logic [SW-1:0]       k_dec;
    logic [W2-1:0]       len_w, cnt_w, cnt_m1;
    lcs_pkg::lcs_flags_t flags;
    logic [SW-1:0]       unit_value;

    lcs_unit #(
        .SW (SW)
    ) u_unit (
        .sym_a (a_rdata_reg),
        .sym_b (b_rdata_reg),
        .diag  (diag_reg),
        .up    (t_rdata_reg),
        .left  (left_reg),
        .cur   (cur_reg),
        .flags (flags),
        .value (unit_value)
    );

    assign accept = in_valid && in_ready;
    assign in_ready = (state_reg == ST_IDLE);
    assign i_dec = i_reg - LW'(1);
    assign j_dec = j_reg - SLW'(1);
    assign k_dec = k_reg - SW'(1);
    assign len_w = {{lcs_pkg::LENOUT_W{1'b0}}, len_reg};
    assign cnt_w = (len_w > W2'(lcs_pkg::RESULT_CAP)) ? W2'(lcs_pkg::RESULT_CAP) : len_w;
    assign cnt_m1 = cnt_w - W2'(1);
    assign border = (i_reg == '0) || (j_reg == '0);
    assign wval = (state_reg == ST_FWR) ? unit_value : '0;

    assign a_waddr = fl_reg[FAW-1:0];
    assign b_waddr = sl_reg[SAW-1:0];
    assign a_raddr = i_dec[FAW-1:0];
    assign b_raddr = j_dec[SAW-1:0];
    assign q_waddr = k_dec[FAW-1:0];
    assign q_raddr = ek_reg;
    assign t_waddr = addr_reg;
    assign t_wdata = wval;

    always_comb begin
        state_next = state_reg;
        fl_next    = fl_reg;
        sl_next    = sl_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        addr_next  = addr_reg;
        diag_next  = diag_reg;
        left_next  = left_reg;
        cur_next   = cur_reg;
        len_next   = len_reg;
        k_next     = k_reg;
        lastk_next = lastk_reg;
        ek_next    = ek_reg;
        empty_next = empty_reg;
        a_we = 1'b0;
        b_we = 1'b0;
        a_re = 1'b0;
        b_re = 1'b0;
        t_we = 1'b0;
        t_re = 1'b0;
        q_we = 1'b0;
        q_re = 1'b0;
        t_raddr = addr_reg;
        go_emit = 1'b0;
        res_valid = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (in_operation == lcs_pkg::OP_FIRST) begin
                        if (fl_reg < LW'(FIRST_MAX)) begin
                            a_we    = 1'b1;
                            fl_next = fl_reg + LW'(1);
                        end
                    end else if (in_operation == lcs_pkg::OP_SECOND) begin
                        if (sl_reg < SLW'(SECOND_MAX)) begin
                            b_we    = 1'b1;
                            sl_next = sl_reg + SLW'(1);
                        end
                    end else if (in_operation == lcs_pkg::OP_COMPUTE) begin
                        i_next     = '0;
                        j_next     = '0;
                        addr_next  = '0;
                        state_next = ST_FCELL;
                    end
                end
            end
            ST_FCELL, ST_FWR: begin
                if (state_reg == ST_FCELL && !border) begin
                    // Interior cell: fetch the score above and the column symbol.
                    t_re       = 1'b1;
                    t_raddr    = addr_reg - ROW_W;
                    b_re       = 1'b1;
                    state_next = ST_FWR;
                end else begin
                    t_we = 1'b1;
                    if (state_reg == ST_FWR) begin
                        left_next = unit_value;
                        diag_next = t_rdata_reg;
                    end else begin
                        left_next = '0;
                        diag_next = '0;
                        a_re      = (j_reg == '0) && (i_reg != '0);
                        state_next = ST_FCELL;
                    end
                    if (j_reg == sl_reg) begin
                        if (i_reg == fl_reg) begin
                            len_next   = wval;
                            k_next     = wval;
                            state_next = ST_TCHK;
                        end else begin
                            i_next     = i_reg + LW'(1);
                            j_next     = '0;
                            addr_next  = addr_reg + ROW_W - AW'(sl_reg);
                            state_next = ST_FCELL;
                        end
                    end else begin
                        j_next     = j_reg + SLW'(1);
                        addr_next  = addr_reg + AW'(1);
                        state_next = ST_FCELL;
                    end
                end
            end
            ST_TCHK: begin
                if (border) begin
                    go_emit = 1'b1;
                end else begin
                    t_re       = 1'b1;
                    a_re       = 1'b1;
                    b_re       = 1'b1;
                    state_next = ST_TCUR;
                end
            end
            ST_TCUR: begin
                cur_next = t_rdata_reg;
                if (t_rdata_reg == '0) begin
                    go_emit = 1'b1;
                end else begin
                    t_re       = 1'b1;
                    t_raddr    = addr_reg - ROW_W;
                    state_next = ST_TDEC;
                end
            end
            ST_TDEC: begin
                state_next = ST_TCHK;
                if (flags.match) begin
                    if (k_reg != '0) begin
                        q_we   = 1'b1;
                        k_next = k_dec;
                    end
                    i_next    = i_dec;
                    j_next    = j_dec;
                    addr_next = addr_reg - ROW_W - AW'(1);
                end else if (flags.up_eq) begin
                    i_next    = i_dec;
                    addr_next = addr_reg - ROW_W;
                end else begin
                    j_next    = j_dec;
                    addr_next = addr_reg - AW'(1);
                end
            end
            ST_ERD: begin
                q_re       = 1'b1;
                state_next = ST_EOUT;
            end
            ST_EOUT: begin
                res_valid = 1'b1;
                if (res_ready) begin
                    if (res.last) begin
                        state_next = ST_IDLE;
                    end else begin
                        ek_next    = ek_reg + FAW'(1);
                        state_next = ST_ERD;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        if (go_emit) begin
            empty_next = (len_reg == '0);
            ek_next    = '0;
            lastk_next = cnt_m1[SW-1:0];
            state_next = (len_reg == '0) ? ST_EOUT : ST_ERD;
        end
    end

    always_comb begin
        res.lcs_length   = len_w[lcs_pkg::LENOUT_W-1:0];
        res.out_symbol   = empty_reg ? '0 : q_rdata_reg;
        res.symbol_valid = !empty_reg;
        res.last         = empty_reg || (SW'(ek_reg) == lastk_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            fl_reg    <= '0;
            sl_reg    <= '0;
        end else begin
            state_reg <= state_next;
            fl_reg    <= fl_next;
            sl_reg    <= sl_next;
        end
    end

    always_ff @(posedge aclk) begin
        i_reg     <= i_next;
        j_reg     <= j_next;
        addr_reg  <= addr_next;
        diag_reg  <= diag_next;
        left_reg  <= left_next;
        cur_reg   <= cur_next;
        len_reg   <= len_next;
        k_reg     <= k_next;
        lastk_reg <= lastk_next;
        ek_reg    <= ek_next;
        empty_reg <= empty_next;
    end

    always_ff @(posedge aclk) begin
        if (a_we) begin
            a_mem[a_waddr] <= in_symbol;
        end
        if (a_re) begin
            a_rdata_reg <= a_mem[a_raddr];
        end
    end

    always_ff @(posedge aclk) begin
        if (b_we) begin
            b_mem[b_waddr] <= in_symbol;
        end
        if (b_re) begin
            b_rdata_reg <= b_mem[b_raddr];
        end
    end

    always_ff @(posedge aclk) begin
        if (t_we) begin
            t_mem[t_waddr] <= t_wdata;
        end
        if (t_re) begin
            t_rdata_reg <= t_mem[t_raddr];
        end
    end

    // The subsequence is gathered back to front during traceback.
    always_ff @(posedge aclk) begin
        if (q_we) begin
            q_mem[q_waddr] <= a_rdata_reg;
        end
        if (q_re) begin
            q_rdata_reg <= q_mem[q_raddr];
        end
    end

endmodule
`default_nettype wire

// ===== design/lcs_length_and_traceback_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// LCS length and traceback core
// Loads two byte strings, computes their longest common subsequence and
// streams its symbols in forward order.
// ----------------------------------------------------------------------------
// A load item (operation 0 or 1) gives no result; symbols beyond FIRST_MAX or
// SECOND_MAX are dropped. A compute item (operation 2) fills the (n+1)*(m+1)
// score table through a single-port score memory, reading the score above
// before writing each interior cell, then traces back from the far corner
// through check, read and decide states (at most n+m steps), then emits the
// results in turn via a read and an output state that waits on the output
// register, or a single empty result. The input is not ready from the compute
// transfer until the last result has been handed to the output register. Loaded
// strings persist across compute requests. Op code 3 is accepted and ignored.
module lcs_length_and_traceback_core #(
    parameter int FIRST_MAX  = lcs_pkg::FIRST_MAX_DEF,
    parameter int SECOND_MAX = lcs_pkg::SECOND_MAX_DEF
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic [lcs_pkg::OP_W-1:0]      s_operation,
    input  wire logic [lcs_pkg::SYM_W-1:0]     s_symbol,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic [lcs_pkg::LENOUT_W-1:0]       m_lcs_length,
    output logic [lcs_pkg::SYM_W-1:0]          m_out_symbol,
    output logic                               m_symbol_valid,
    output logic                               m_last
);

    logic              eng_valid;
    logic              eng_ready;
    lcs_pkg::lcs_res_t eng_res;
    logic              m_valid_reg;
    lcs_pkg::lcs_res_t m_res_reg;

    lcs_engine #(
        .FIRST_MAX  (FIRST_MAX),
        .SECOND_MAX (SECOND_MAX)
    ) u_engine (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .in_valid     (s_valid),
        .in_ready     (s_ready),
        .in_operation (s_operation),
        .in_symbol    (s_symbol),
        .res_valid    (eng_valid),
        .res_ready    (eng_ready),
        .res          (eng_res)
    );

    // Output register: the engine can load it whenever it is empty or draining.
    assign eng_ready = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (eng_ready) begin
            m_valid_reg <= eng_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (eng_ready && eng_valid) begin
            m_res_reg <= eng_res;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_lcs_length   = m_res_reg.lcs_length;
    assign m_out_symbol   = m_res_reg.out_symbol;
    assign m_symbol_valid = m_res_reg.symbol_valid;
    assign m_last         = m_res_reg.last;

    a_compute_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && (s_operation == lcs_pkg::OP_COMPUTE) |=> !s_ready)
        else $error("input ready right after a compute transfer");

    a_no_result_when_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && eng_valid))
        else $error("engine offers a result while taking input");

    a_empty_result: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_symbol_valid |-> (m_lcs_length == '0) && m_last)
        else $error("empty result with nonzero length or not last");

endmodule
`default_nettype wire
